// ===== rtl/core/interval_binary_search_unit_defines.svh =====
// Assertion macros for the interval binary search unit.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef INTERVAL_BINARY_SEARCH_UNIT_DEFINES_SVH
`define INTERVAL_BINARY_SEARCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define IBS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interval_binary_search_unit: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define IBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interval_binary_search_unit: next-cycle check failed");
`else
`define IBS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define IBS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/ibs_pkg.sv =====
// Shared types and constants for the interval binary search unit.
// No dependencies; used by the sequencer, the datapath and the top level.
package ibs_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int INDEX_W     = 8;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 9;
   localparam int RESULT_W    = 9;
   // signed search bounds: range -1 .. TABLE_DEPTH-1, and their sum
   localparam int PTR_W       = ADDR_W + 2;

   localparam logic                COMMAND_WRITE = 1'b0;
   localparam logic                COMMAND_QUERY = 1'b1;
   localparam logic [RESULT_W-1:0] RESULT_BELOW  = {RESULT_W{1'b1}};

   // microprogram step addresses
   typedef enum logic [2:0] {
      STEP_IDLE      = 3'd0,
      STEP_EDGE_READ = 3'd1,
      STEP_EDGE_TEST = 3'd2,
      STEP_LOOP_TEST = 3'd3,
      STEP_PROBE     = 3'd4,
      STEP_EMIT      = 3'd5
   } step_type;

   typedef enum logic {
      RD_EDGES = 1'b0,
      RD_MID   = 1'b1
   } rd_sel_type;

   typedef enum logic [1:0] {
      TST_NONE  = 2'd0,
      TST_EDGES = 2'd1,
      TST_LOOP  = 2'd2,
      TST_PROBE = 2'd3
   } test_type;

   typedef struct packed {
      logic       accept;
      logic       emit;
      rd_sel_type read_sel;
      test_type   test;
      step_type   next_step;
      step_type   jump_step;
   } ctrl_word_type;

   typedef struct packed {
      logic hold;
      logic taken;
   } dp_status_type;

endpackage

// ===== rtl/core/ibs_sequencer.sv =====
// Microcode sequencer: step counter plus the control-word ROM.
// Depends on ibs_pkg.
module ibs_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  ibs_pkg::dp_status_type status,
   output ibs_pkg::ctrl_word_type ctrl,
   output ibs_pkg::step_type      step
);

   ibs_pkg::step_type step_ff;
   ibs_pkg::step_type step_in;

   // control store
   always_comb begin
      ctrl = '{accept: 1'b0, emit: 1'b0, read_sel: ibs_pkg::RD_EDGES,
               test: ibs_pkg::TST_NONE, next_step: ibs_pkg::STEP_IDLE,
               jump_step: ibs_pkg::STEP_IDLE};
      unique case (step_ff)
         ibs_pkg::STEP_IDLE: begin
            ctrl.accept    = 1'b1;
            ctrl.next_step = ibs_pkg::STEP_EDGE_READ;
         end
         ibs_pkg::STEP_EDGE_READ: begin
            ctrl.read_sel  = ibs_pkg::RD_EDGES;
            ctrl.next_step = ibs_pkg::STEP_EDGE_TEST;
         end
         ibs_pkg::STEP_EDGE_TEST: begin
            ctrl.test      = ibs_pkg::TST_EDGES;
            ctrl.next_step = ibs_pkg::STEP_LOOP_TEST;
            ctrl.jump_step = ibs_pkg::STEP_EMIT;
         end
         ibs_pkg::STEP_LOOP_TEST: begin
            ctrl.read_sel  = ibs_pkg::RD_MID;
            ctrl.test      = ibs_pkg::TST_LOOP;
            ctrl.next_step = ibs_pkg::STEP_PROBE;
            ctrl.jump_step = ibs_pkg::STEP_EMIT;
         end
         ibs_pkg::STEP_PROBE: begin
            ctrl.test      = ibs_pkg::TST_PROBE;
            ctrl.next_step = ibs_pkg::STEP_LOOP_TEST;
            ctrl.jump_step = ibs_pkg::STEP_EMIT;
         end
         ibs_pkg::STEP_EMIT: begin
            ctrl.emit      = 1'b1;
            ctrl.next_step = ibs_pkg::STEP_IDLE;
         end
         default: begin
            ctrl.next_step = ibs_pkg::STEP_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (status.hold) begin
         step_in = step_ff;
      end else if (status.taken) begin
         step_in = ctrl.jump_step;
      end else begin
         step_in = ctrl.next_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ibs_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign step = step_ff;

endmodule

// ===== rtl/core/ibs_datapath.sv =====
// Search datapath: boundary memory, key and bound registers, comparators.
// Depends on ibs_pkg; driven by control words from ibs_sequencer.
module ibs_datapath (
   input  logic                                 clock,
   input  ibs_pkg::ctrl_word_type                ctrl,
   input  logic                                 req_fire,
   input  logic                                 command,
   input  logic [ibs_pkg::INDEX_W-1:0]          entry_index,
   input  logic signed [ibs_pkg::VALUE_W-1:0]   entry_value,
   input  logic signed [ibs_pkg::VALUE_W-1:0]   search_key,
   input  logic [ibs_pkg::COUNT_W-1:0]          boundary_count,
   input  logic                                 slot_free,
   output ibs_pkg::dp_status_type                status,
   output logic [ibs_pkg::RESULT_W-1:0]         result
);

   logic signed [ibs_pkg::VALUE_W-1:0] table_mem [ibs_pkg::TABLE_DEPTH];
   logic signed [ibs_pkg::VALUE_W-1:0] rd_a_ff;
   logic signed [ibs_pkg::VALUE_W-1:0] rd_b_ff;
   logic signed [ibs_pkg::VALUE_W-1:0] key_ff;
   logic signed [ibs_pkg::PTR_W-1:0]   lo_ff, lo_in;
   logic signed [ibs_pkg::PTR_W-1:0]   hi_ff, hi_in;
   logic signed [ibs_pkg::PTR_W-1:0]   ptr_sum;
   logic [ibs_pkg::ADDR_W-1:0]         mid_ff, mid_in;
   logic [ibs_pkg::ADDR_W-1:0]         last_idx;
   logic [ibs_pkg::ADDR_W-1:0]         addr_a, addr_b;
   logic [ibs_pkg::RESULT_W-1:0]       result_ff, result_in;
   logic                               query_fire;
   logic                               key_lt_a, key_lt_b, lo_lt_hi, hit;

   assign query_fire = req_fire && (command == ibs_pkg::COMMAND_QUERY);

   // clamp count to 1 .. TABLE_DEPTH, keep the last index in use
   always_comb begin
      priority if (boundary_count == '0) begin
         last_idx = '0;
      end else if (32'(boundary_count) > ibs_pkg::TABLE_DEPTH) begin
         last_idx = ibs_pkg::ADDR_W'(ibs_pkg::TABLE_DEPTH - 1);
      end else begin
         last_idx = ibs_pkg::ADDR_W'(boundary_count - 1'b1);
      end
   end

   assign ptr_sum = lo_ff + hi_ff;
   assign mid_in  = ptr_sum[ibs_pkg::ADDR_W:1];

   always_comb begin
      unique case (ctrl.read_sel)
         ibs_pkg::RD_EDGES: begin
            addr_a = '0;
            addr_b = last_idx;
         end
         ibs_pkg::RD_MID: begin
            addr_a = mid_in;
            addr_b = ibs_pkg::ADDR_W'(mid_in + 1'b1);
         end
         default: begin
            addr_a = '0;
            addr_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire && (command == ibs_pkg::COMMAND_WRITE) &&
          (32'(entry_index) < ibs_pkg::TABLE_DEPTH)) begin
         table_mem[ibs_pkg::ADDR_W'(entry_index)] <= entry_value;
      end
      rd_a_ff <= table_mem[addr_a];
      rd_b_ff <= table_mem[addr_b];
   end

   assign key_lt_a = key_ff < rd_a_ff;
   assign key_lt_b = key_ff < rd_b_ff;
   assign lo_lt_hi = lo_ff < hi_ff;
   assign hit      = !key_lt_a && key_lt_b;

   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      result_in = result_ff;
      unique case (ctrl.test)
         ibs_pkg::TST_EDGES: begin
            lo_in = '0;
            hi_in = ibs_pkg::PTR_W'(last_idx) - ibs_pkg::PTR_W'(1);
            priority if (key_lt_a) begin
               result_in = ibs_pkg::RESULT_BELOW;
            end else if (!key_lt_b) begin
               result_in = ibs_pkg::RESULT_W'(last_idx);
            end
         end
         ibs_pkg::TST_LOOP: begin
            if (!lo_lt_hi) begin
               result_in = ibs_pkg::RESULT_W'(lo_ff);
            end
         end
         ibs_pkg::TST_PROBE: begin
            priority if (hit) begin
               result_in = ibs_pkg::RESULT_W'(mid_ff);
            end else if (key_lt_a) begin
               hi_in = ibs_pkg::PTR_W'(mid_ff) - ibs_pkg::PTR_W'(1);
            end else begin
               lo_in = ibs_pkg::PTR_W'(mid_ff) + ibs_pkg::PTR_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (query_fire) begin
         key_ff <= search_key;
      end
      if (ctrl.test == ibs_pkg::TST_LOOP) begin
         mid_ff <= mid_in;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      result_ff <= result_in;
   end

   always_comb begin
      status.hold = (ctrl.accept && !query_fire) || (ctrl.emit && !slot_free);
      unique case (ctrl.test)
         ibs_pkg::TST_EDGES: status.taken = key_lt_a || !key_lt_b;
         ibs_pkg::TST_LOOP:  status.taken = !lo_lt_hi;
         ibs_pkg::TST_PROBE: status.taken = hit;
         default:            status.taken = 1'b0;
      endcase
   end

   assign result = result_ff;

endmodule

// ===== rtl/core/interval_binary_search_unit.sv =====
// Interval binary search unit, top level: handshakes, count register, result slot.
// Depends on ibs_pkg, ibs_sequencer, ibs_datapath and the defines header.
//
//   channel  | direction | beat contents
//   ---------+-----------+-----------------------------------------------------
//   req_*    | in        | write (entry_index, entry_value) or query (search_key)
//   rsp_*    | out       | interval_index, one beat per query
//   csr_*    | in        | boundary_count
//
// A write beat is taken at the idle step. A query whose key falls outside the
// table edges goes from the edge read and edge test straight to emit; otherwise
// it bisects, each bisection step a probe read and a compare, at most seven steps
// on a full table, as the two-port table read is registered.
// Reset clears the step counter, the result slot and sets the count to 1;
// table contents are undefined until written.
// A stalled rsp side holds the sequencer on its emit step; a waiting result
// does not block acceptance of the next req beat.
`include "interval_binary_search_unit_defines.svh"

module interval_binary_search_unit (
   input  logic        clock,
   input  logic        reset,
   // req channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // entry_index[7:0], entry_value[39:8], search_key[71:40]
   input  logic        req_tuser,   // command (0 write, 1 query)
   // rsp channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // interval_index[8:0], zero fill [15:9]
   // csr channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_wdata    // boundary_count
);

   ibs_pkg::ctrl_word_type ctrl;
   ibs_pkg::dp_status_type status;
   ibs_pkg::step_type      step;

   logic [ibs_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [ibs_pkg::RESULT_W-1:0] rsp_data_ff, rsp_data_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ibs_pkg::RESULT_W-1:0] result;
   logic                         req_fire;
   logic                         slot_free;
   logic                         rsp_load;

   assign csr_ready  = 1'b1;
   assign req_tready = ctrl.accept;
   assign req_fire   = req_tvalid && req_tready;

   // result slot is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load  = ctrl.emit && slot_free;

   ibs_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .step   (step)
   );

   ibs_datapath u_dp (
      .clock          (clock),
      .ctrl           (ctrl),
      .req_fire       (req_fire),
      .command        (req_tuser),
      .entry_index    (req_tdata[7:0]),
      .entry_value    (req_tdata[39:8]),
      .search_key     (req_tdata[71:40]),
      .boundary_count (count_ff),
      .slot_free      (slot_free),
      .status         (status),
      .result         (result)
   );

   // count register: take csr beats as they come
   assign count_in = (csr_valid && csr_ready) ? csr_wdata : count_ff;

   // result slot: load on emit, drop on drain
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= ibs_pkg::COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff};

   // a query beat starts the edge reads on the next cycle
   `IBS_ASSERT_NEXT(a_query_starts, clock, reset, req_fire && (req_tuser == ibs_pkg::COMMAND_QUERY), step == ibs_pkg::STEP_EDGE_READ)
   // a result is only loaded into a free slot
   `IBS_ASSERT_NOW(a_load_free_slot, clock, reset, rsp_load, !rsp_valid_ff || rsp_tready)
   // an emit with a free slot presents a result next cycle
   `IBS_ASSERT_NEXT(a_emit_shows, clock, reset, (step == ibs_pkg::STEP_EMIT) && slot_free, rsp_tvalid && (step == ibs_pkg::STEP_IDLE))
   // input is taken only at the idle step
   `IBS_ASSERT_NOW(a_ready_idle, clock, reset, req_tready, step == ibs_pkg::STEP_IDLE)

endmodule

// ===== tb/interval_binary_search_unit_tb.sv =====
// Self-checking testbench for interval_binary_search_unit: table loads, interval queries,
// boundary_count writes, random pacing on both stream sides. Depends on ibs_pkg and the RTL.
`timescale 1ns / 1ps

module interval_binary_search_unit_tb;

   localparam int IDLE_PCT         = 62;
   localparam int BOTH_PCT         = 19;
   localparam int SETTLE_CYCLES    = 30;    // longest query plus margin
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int BEAT_TARGET      = 1720;  // directed beats plus about 1700 random ones
   localparam int PRESSURE_PHASE   = 4;

   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic               command;
      logic [7:0]         entry_index;
      logic signed [31:0] entry_value;
      logic signed [31:0] search_key;
   } req_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // entry_index[7:0], entry_value[39:8], search_key[71:40]
   logic        req_tuser = 1'b0; // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // interval_index[8:0], zero fill [15:9]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_wdata = '0;

   // pending request beats, expected interval indexes
   req_beat_type       pending_beats[$];
   logic [8:0]         expected_intervals[$];

   // predictor state, updated on accepted beats
   logic signed [31:0] boundary_mirror [ibs_pkg::TABLE_DEPTH];
   logic [8:0]         count_mirror = 9'd1;

   // stimulus-side view of the table
   logic signed [31:0] gen_value [ibs_pkg::TABLE_DEPTH];
   int                 gen_count = 1;
   int                 beats_queued = 0;

   int                 req_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   int                 hold_seq = 0;
   int                 hold_seen = 0;
   int                 hold_left = 0;
   int                 quiet_cycles = 0;
   int                 fail_count = 0;

   interval_binary_search_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // zero counts as one, anything above the table depth saturates
   function automatic int effective_count(input logic [8:0] raw);
      int n;
      n = raw;
      if (n < 1) n = 1;
      if (n > ibs_pkg::TABLE_DEPTH) n = ibs_pkg::TABLE_DEPTH;
      return n;
   endfunction

   // Edge checks first, then bisect the interior intervals 0 .. n-2.
   function automatic logic [8:0] locate_interval(input logic signed [31:0] key);
      int n;
      int lo;
      int hi;
      int mid;
      int found;
      bit hit;
      n = effective_count(count_mirror);
      if (key < boundary_mirror[0]) return ibs_pkg::RESULT_BELOW;
      if (key >= boundary_mirror[n-1]) return 9'(n - 1);
      lo = 0;
      hi = n - 2;
      hit = 1'b0;
      found = 0;
      while (lo < hi && !hit) begin
         mid = (lo + hi) / 2;
         if (key >= boundary_mirror[mid] && key < boundary_mirror[mid+1]) begin
            hit = 1'b1;
            found = mid;
         end else if (key < boundary_mirror[mid]) begin
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      if (!hit) found = lo;
      return 9'(found);
   endfunction

   // request driver: advance to the next beat once the current one is taken
   always @(posedge clock) begin : drive_req
      req_beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_beats.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            beat = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= beat.command;
            req_tdata  <= {beat.search_key, beat.entry_value, beat.entry_index};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready: random stalls, plus one long hold-off when asked
   always @(posedge clock) begin : pace_rsp
      if (hold_seen != hold_seq) begin
         hold_seen  <= hold_seq;
         hold_left  <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // monitor: update the predictor on accepted beats, check every result beat
   always @(posedge clock) begin : watch_beats
      logic [8:0] want;
      if (reset) begin
         count_mirror = 9'd1;
      end else begin
         if (csr_valid && csr_ready) count_mirror = csr_wdata;
         if (req_tvalid && req_tready) begin
            if (req_tuser == ibs_pkg::COMMAND_WRITE) begin
               if (int'(req_tdata[7:0]) < ibs_pkg::TABLE_DEPTH)
                  boundary_mirror[req_tdata[7:0]] = req_tdata[39:8];
            end else begin
               expected_intervals.push_back(locate_interval(req_tdata[71:40]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_intervals.size() == 0) begin
               $display("%0t: unexpected result beat, interval_index %0d",
                        $time, $signed(rsp_tdata[8:0]));
               fail_count++;
            end else begin
               want = expected_intervals.pop_front();
               if (rsp_tdata[8:0] !== want) begin
                  $display("%0t: interval_index mismatch, expected %0d, actual %0d",
                           $time, $signed(want), $signed(rsp_tdata[8:0]));
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("interval_binary_search_unit regression: fail");
         $finish;
      end
   end

   task automatic push_write(input int idx, input logic signed [31:0] value);
      req_beat_type beat;
      beat.command     = ibs_pkg::COMMAND_WRITE;
      beat.entry_index = idx[7:0];
      beat.entry_value = value;
      beat.search_key  = $urandom();   // don't-care on a write
      gen_value[idx]   = value;
      pending_beats.push_back(beat);
      beats_queued++;
   endtask

   task automatic push_query(input logic signed [31:0] key);
      req_beat_type beat;
      beat.command     = ibs_pkg::COMMAND_QUERY;
      beat.entry_index = $urandom_range(0, 255);   // don't-care on a query
      beat.entry_value = $urandom();
      beat.search_key  = key;
      pending_beats.push_back(beat);
      beats_queued++;
   endtask

   // Wait until the block has nothing left in flight, then let the sequencer drain.
   task automatic settle_block();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_tvalid || expected_intervals.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_boundary_count(input logic [8:0] value);
      settle_block();
      @(posedge clock);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      gen_count = effective_count(value);
   endtask

   // Load entries 0 .. n-1 with an ascending set: wide spread, tight with
   // duplicates, or a narrow random band. Index order is up or down at random.
   task automatic load_sorted(input int n);
      logic signed [31:0] vals [ibs_pkg::TABLE_DEPTH];
      longint             cur;
      longint             step_max;
      int                 style;
      int                 i;
      style = $urandom_range(0, 2);
      case (style)
         0: begin
            step_max = 64'd4294967295 / n;
            cur = -64'sd2147483648 + longint'($urandom_range(0, 32'(step_max / 4)));
         end
         1: begin
            step_max = 3;
            cur = longint'(int'($urandom()));
         end
         default: begin
            step_max = 5000;
            cur = longint'(int'($urandom()));
         end
      endcase
      for (i = 0; i < n; i++) begin
         if (cur > 64'sd2147483647) cur = 64'sd2147483647;
         vals[i] = cur[31:0];
         cur = cur + longint'($urandom_range(0, 32'(step_max)));
      end
      if (style == 0 && $urandom_range(0, 1) == 1) vals[n-1] = KEY_MAX;
      if ($urandom_range(0, 1) == 1) begin
         for (i = 0; i < n; i++) push_write(i, vals[i]);
      end else begin
         for (i = n - 1; i >= 0; i--) push_write(i, vals[i]);
      end
   endtask

   // Half the keys on or next to a boundary, the rest extremes and raw noise.
   function automatic logic signed [31:0] pick_search_key();
      int                 roll;
      logic signed [31:0] edge_val;
      roll = $urandom_range(0, 99);
      edge_val = gen_value[$urandom_range(0, gen_count - 1)];
      if (roll < 30) return edge_val;
      if (roll < 50) return ($urandom_range(0, 1) == 1) ? edge_val + 32'sd1 : edge_val - 32'sd1;
      if (roll < 60) return KEY_MIN;
      if (roll < 65) return KEY_MAX;
      return $urandom();
   endfunction

   initial begin : stimulus
      int          phase;
      int          n_queries;
      logic [8:0]  count_value;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset count of one, extreme indexes and values
      push_write(0, -32'sd5);
      push_write(255, KEY_MAX);
      push_write(128, KEY_MIN);
      push_query(KEY_MIN);
      push_query(-32'sd6);
      push_query(-32'sd5);
      push_query(KEY_MAX);

      // count of zero behaves as one
      write_boundary_count(9'd0);
      @(negedge clock);
      push_query(-32'sd6);
      push_query(-32'sd5);

      // five entries spanning the full range with a duplicated boundary
      write_boundary_count(9'd5);
      @(negedge clock);
      push_write(0, KEY_MIN);
      push_write(1, -32'sd100);
      push_write(2, -32'sd100);
      push_write(3, 32'sd50);
      push_write(4, KEY_MAX);
      push_query(KEY_MIN);
      push_query(-32'sd101);
      push_query(-32'sd100);
      push_query(32'sd0);
      push_query(32'sd50);
      push_query(KEY_MAX - 32'sd1);
      push_query(KEY_MAX);

      // random phases: new count, fresh sorted load, then queries with some stray writes
      for (phase = 0; beats_queued < BEAT_TARGET; phase++) begin
         if (phase % 9 == 5) begin
            case ((phase / 9) % 3)
               0:       count_value = 9'd511;
               1:       count_value = 9'd256;
               default: count_value = 9'($urandom_range(257, 510));
            endcase
         end else if ($urandom_range(0, 4) == 0) begin
            count_value = 9'($urandom_range(17, 64));
         end else begin
            count_value = 9'($urandom_range(0, 16));
         end
         write_boundary_count(count_value);
         @(negedge clock);
         case (phase % 4)
            0: begin req_idle_pct = 0;        rsp_stall_pct = 0;        end
            1: begin req_idle_pct = IDLE_PCT; rsp_stall_pct = 0;        end
            2: begin req_idle_pct = 0;        rsp_stall_pct = IDLE_PCT; end
            default: begin req_idle_pct = BOTH_PCT; rsp_stall_pct = BOTH_PCT; end
         endcase
         load_sorted(gen_count);
         n_queries = $urandom_range(30, 60);
         repeat (n_queries) begin
            if ($urandom_range(0, 99) < 8)
               push_write($urandom_range(0, 255), $urandom());
            else
               push_query(pick_search_key());
         end
         // hold off the result side while the sender keeps offering
         if (phase == PRESSURE_PHASE) hold_seq++;
      end

      settle_block();
      if (fail_count == 0 && expected_intervals.size() == 0)
         $display("interval_binary_search_unit regression: pass");
      else
         $display("interval_binary_search_unit regression: fail");
      $finish;
   end

endmodule
